// ===== rtl/core/sgs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sgs_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 11;
	localparam int ROW_W       = 11;
	localparam int GRAD_W      = 11;
	localparam int SUM_W       = 10;
	localparam int REG_IDX_W   = 1;
	localparam int CFG_MAX     = (1 << CFG_W) - 1;
	localparam int MIN_DIM     = 3;
	localparam int MAX_HEIGHT  = 1024;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic emit;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} pos_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/sgs_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sgs_in_if import sgs_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             flush;

	modport source (output valid, output pixel, output flush, input ready);
	modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface sgs_out_if import sgs_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic                     frame_end;

	modport source (output valid, output grad_x, output grad_y, output frame_end, input ready);
	modport sink (input valid, input grad_x, input grad_y, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sobel_gradient_stream.sv =====
// Sobel gradient filter over a raster pixel stream, 3x3 window, zero padding.
// pix_in carries one word per pixel (pixel, flush); grad_out carries one word
// per image position (grad_x, grad_y, frame_end), both valid/ready channels.
// Registers image_width (index 0) and image_height (index 1) are written over
// cfg_we/cfg_index/cfg_data; a write restarts the frame. Write only when idle.
// The result for pixel (i,j) is released by the word width+1 positions later;
// after the last pixel send width+1 flush words to drain the frame.
// Registered path from the accepted releasing word to its result: queue, line
// memory read, window, window sums. Throughput, while grad_out is ready: one
// word per clock on both channels, set by the line memory, which takes one
// read and one write (at another column) per word.
// Reset: 640 x 480, counters at the frame start, line memory not cleared.
// When grad_out stalls the back end holds; the 4-entry queue absorbs input
// until it fills, then pix_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module sobel_gradient_stream import sgs_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	sgs_in_if.sink                    pix_in,
	sgs_out_if.source                 grad_out
);

	localparam int LINE_DEPTH = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
	localparam int AW         = $clog2(LINE_DEPTH);
	localparam int FLAG_W     = $bits(pos_flags_t);
	localparam int QDW        = PIX_W + AW + FLAG_W;

	logic             push;
	logic             push_ready;
	logic [PIX_W-1:0] push_pixel;
	logic [AW-1:0]    push_addr;
	pos_flags_t       push_flags;
	logic             pop;
	logic             pop_valid;
	logic [QDW-1:0]   pop_data;
	logic [PIX_W-1:0] pop_pixel;
	logic [AW-1:0]    pop_addr;
	pos_flags_t       pop_flags;

	sgs_front #(
		.LINE_DEPTH (LINE_DEPTH),
		.AW         (AW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in),
		.q_ready   (push_ready),
		.q_push    (push),
		.q_pixel   (push_pixel),
		.q_addr    (push_addr),
		.q_flags   (push_flags)
	);

	sgs_queue #(
		.DW    (QDW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_pixel, push_addr, push_flags}),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	assign pop_pixel = pop_data[QDW-1 -: PIX_W];
	assign pop_addr  = pop_data[FLAG_W +: AW];
	assign pop_flags = pos_flags_t'(pop_data[FLAG_W-1:0]);

	sgs_back #(
		.LINE_DEPTH (LINE_DEPTH),
		.AW         (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_pixel  (pop_pixel),
		.q_addr   (pop_addr),
		.q_flags  (pop_flags),
		.q_pop    (pop),
		.grad_out (grad_out)
	);

endmodule

`default_nettype wire

// ===== rtl/core/sgs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgs_front import sgs_pkg::*; #(
	parameter int LINE_DEPTH = 1024,
	parameter int AW         = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	sgs_in_if.sink                    pix_in,
	input  wire logic                 q_ready,
	output logic                      q_push,
	output logic [PIX_W-1:0]          q_pixel,
	output logic [AW-1:0]             q_addr,
	output pos_flags_t                q_flags
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [AW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [CFG_W-1:0] col_ext;
	logic             col_zero;
	logic             in_frame;
	logic             drop;
	logic             wrap;

	assign pix_in.ready = q_ready;

	always_comb begin
		priority if (width_q < CFG_W'(MIN_DIM)) begin
			w_eff = CFG_W'(MIN_DIM);
		end else if (width_q > CFG_W'(LINE_DEPTH)) begin
			w_eff = CFG_W'(LINE_DEPTH);
		end else begin
			w_eff = width_q;
		end
		priority if (height_q < CFG_W'(MIN_DIM)) begin
			h_eff = CFG_W'(MIN_DIM);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_eff = CFG_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	always_comb begin
		col_ext  = CFG_W'(col_q);
		col_zero = (col_q == '0);
		in_frame = (row_q < h_eff);
		drop     = in_frame && pix_in.flush;
		q_push   = pix_in.valid && q_ready && !drop;
		wrap     = ((col_ext + CFG_W'(1)) >= w_eff);
		q_pixel  = in_frame ? pix_in.pixel : '0;
		q_addr   = col_q;

		q_flags.emit   = !((row_q == '0) || ((row_q == ROW_W'(1)) && col_zero));
		q_flags.top    = col_zero ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
		q_flags.bottom = col_zero ? (row_q == (h_eff + CFG_W'(1))) : (row_q == h_eff);
		q_flags.left   = !col_zero && (col_q == AW'(1));
		q_flags.right  = col_zero;
		q_flags.last   = q_flags.emit && q_flags.bottom && q_flags.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			priority if (q_flags.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CFG_W'(col_q) < w_eff)
		else $error("column counter beyond image width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= (h_eff + CFG_W'(1)))
		else $error("row counter beyond drain row");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> ((col_q == '0) && (row_q == '0)))
		else $error("register write did not restart the frame");

endmodule

`default_nettype wire

// ===== rtl/core/sgs_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgs_queue #(
	parameter int DW    = 24,
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [DW-1:0] push_data,
	output logic               push_ready,
	output logic               pop_valid,
	input  wire logic          pop,
	output logic [DW-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/core/sgs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgs_back import sgs_pkg::*; #(
	parameter int LINE_DEPTH = 1024,
	parameter int AW         = 10
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire logic [PIX_W-1:0] q_pixel,
	input  wire logic [AW-1:0]    q_addr,
	input  wire pos_flags_t       q_flags,
	output logic                  q_pop,
	sgs_out_if.source             grad_out
);

	// entry: [hi] one row above, [lo] two rows above
	logic [2*PIX_W-1:0] line_mem [LINE_DEPTH];
	logic [2*PIX_W-1:0] rd_q;

	logic               adv;
	logic               valid_s1;
	logic [PIX_W-1:0]   pixel_s1;
	logic [AW-1:0]      addr_s1;
	pos_flags_t         flags_s1;
	logic               valid_s2;
	pos_flags_t         flags_s2;
	logic [PIX_W-1:0]   win_q [3][3];
	logic [PIX_W-1:0]   tap [3][3];

	logic [SUM_W-1:0]         gx_pos;
	logic [SUM_W-1:0]         gx_neg;
	logic [SUM_W-1:0]         gy_pos;
	logic [SUM_W-1:0]         gy_neg;
	logic                     out_valid_q;
	logic signed [GRAD_W-1:0] grad_x_q;
	logic signed [GRAD_W-1:0] grad_y_q;
	logic                     frame_end_q;

	assign adv   = !out_valid_q || grad_out.ready;
	assign q_pop = adv && q_valid;

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= line_mem[q_addr];
			if (valid_s1) begin
				line_mem[addr_s1] <= {pixel_s1, rd_q[2*PIX_W-1:PIX_W]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_s1 <= q_pixel;
			addr_s1  <= q_addr;
			flags_s1 <= q_flags;
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					win_q[a][b] <= '0;
				end
			end
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1 && flags_s1.emit;
			if (valid_s1) begin
				for (int a = 0; a < 3; a++) begin
					win_q[a][0] <= win_q[a][1];
					win_q[a][1] <= win_q[a][2];
				end
				win_q[0][2] <= rd_q[PIX_W-1:0];
				win_q[1][2] <= rd_q[2*PIX_W-1:PIX_W];
				win_q[2][2] <= pixel_s1;
			end
		end
	end

	// zero the taps that fall outside the image
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if ((a == 0 && flags_s2.top) || (a == 2 && flags_s2.bottom) ||
				    (b == 0 && flags_s2.left) || (b == 2 && flags_s2.right)) begin
					tap[a][b] = '0;
				end else begin
					tap[a][b] = win_q[a][b];
				end
			end
		end
		gx_pos = SUM_W'(tap[0][0]) + (SUM_W'(tap[1][0]) << 1) + SUM_W'(tap[2][0]);
		gx_neg = SUM_W'(tap[0][2]) + (SUM_W'(tap[1][2]) << 1) + SUM_W'(tap[2][2]);
		gy_pos = SUM_W'(tap[0][0]) + (SUM_W'(tap[0][1]) << 1) + SUM_W'(tap[0][2]);
		gy_neg = SUM_W'(tap[2][0]) + (SUM_W'(tap[2][1]) << 1) + SUM_W'(tap[2][2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grad_x_q    <= $signed(GRAD_W'(gx_pos) - GRAD_W'(gx_neg));
			grad_y_q    <= $signed(GRAD_W'(gy_pos) - GRAD_W'(gy_neg));
			frame_end_q <= flags_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	assign grad_out.valid     = out_valid_q;
	assign grad_out.grad_x    = grad_x_q;
	assign grad_out.grad_y    = grad_y_q;
	assign grad_out.frame_end = frame_end_q;

	a_last_is_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && flags_s2.last) |-> (flags_s2.bottom && flags_s2.right))
		else $error("frame end away from bottom right corner");

	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(flags_s2.left && flags_s2.right))
		else $error("left and right edge on one position");

endmodule

`default_nettype wire
